// ===== src/ascii_hex_command_register_bridge_defines.svh =====
// assertion macros for the ascii hex command register bridge
`ifndef ASCII_HEX_COMMAND_REGISTER_BRIDGE_DEFINES_SVH
`define ASCII_HEX_COMMAND_REGISTER_BRIDGE_DEFINES_SVH

`ifndef SYNTHESIS
`define AHCRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AHCRB_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define AHCRB_ASSERT(label, prop, msg)
`define AHCRB_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ===== src/ahcrb_pkg.sv =====
// shared constants, types and helper functions of the command bridge
package ahcrb_pkg;

  localparam int LINE_BYTES   = 10;
  localparam int CONFIG_DEPTH = 256;
  localparam int STATUS_DEPTH = 256;

  localparam int CFG_AW    = (CONFIG_DEPTH > 1) ? $clog2(CONFIG_DEPTH) : 1;
  localparam int ST_AW     = (STATUS_DEPTH > 1) ? $clog2(STATUS_DEPTH) : 1;
  localparam int CLR_DEPTH = (CONFIG_DEPTH > STATUS_DEPTH) ? CONFIG_DEPTH : STATUS_DEPTH;
  localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
  localparam int CNT_W     = $clog2(LINE_BYTES + 1);
  localparam int IDX_W     = $clog2(LINE_BYTES);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_S_UP  = 8'h53;
  localparam logic [7:0] CH_S_LO  = 8'h73;
  localparam logic [7:0] CH_R_UP  = 8'h52;
  localparam logic [7:0] CH_R_LO  = 8'h72;
  localparam logic [7:0] CH_W_UP  = 8'h57;
  localparam logic [7:0] CH_W_LO  = 8'h77;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_F_UP  = 8'h46;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'h37;

  typedef enum logic [1:0] {
    CMD_BAD,
    CMD_STATUS,
    CMD_READ,
    CMD_WRITE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  addr;
    logic [15:0] data;
  } line_cmd_t;

  typedef enum logic [1:0] {
    RPL_ERR,
    RPL_OK,
    RPL_WORD
  } reply_kind_t;

  typedef struct packed {
    reply_kind_t kind;
    logic [15:0] word;
  } reply_start_t;

  function automatic logic hex_ok(input logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_A_UP) && (c <= CH_F_UP)) ||
           ((c >= CH_A_LO) && (c <= CH_F_LO));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c <= CH_9) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_0 + {4'b0000, nib};
    end else begin
      c = HEX_ALPHA_OFS + {4'b0000, nib};
    end
    return c;
  endfunction

endpackage

// ===== src/ahcrb_ram.sv =====
// generic single-port-write ram with registered read
module ahcrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ahcrb_line.sv =====
// line buffer that gathers received bytes and decodes the finished line
module ahcrb_line (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [7:0]           push_byte,
  output ahcrb_pkg::line_cmd_t cmd
);
  import ahcrb_pkg::*;

  logic [7:0]       line_r [LINE_BYTES];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic is_s, is_r, is_w, sr_ok, w_ok;
  logic [7:0]  addr;
  logic [15:0] data;

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      if (push_byte == CH_LF) begin
        count_nxt = '0;
      end else if (count_r < CNT_W'(LINE_BYTES)) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < LINE_BYTES; i++) begin
        line_r[i] <= '0;
      end
    end else begin
      count_r <= count_nxt;
      if (push && (count_r < CNT_W'(LINE_BYTES))) begin
        line_r[count_r[IDX_W-1:0]] <= push_byte;
      end
    end
  end

  always_comb begin
    is_s  = (line_r[0] == CH_S_UP) || (line_r[0] == CH_S_LO);
    is_r  = (line_r[0] == CH_R_UP) || (line_r[0] == CH_R_LO);
    is_w  = (line_r[0] == CH_W_UP) || (line_r[0] == CH_W_LO);
    sr_ok = hex_ok(line_r[1]) && hex_ok(line_r[2]) &&
            (line_r[3] == CH_CR) && (line_r[4] == CH_LF);
    w_ok  = hex_ok(line_r[1]) && hex_ok(line_r[2]) && hex_ok(line_r[3]) &&
            hex_ok(line_r[4]) && hex_ok(line_r[5]) && hex_ok(line_r[6]) &&
            (line_r[7] == CH_CR) && (line_r[8] == CH_LF);
    addr  = {hex_val(line_r[1]), hex_val(line_r[2])};
    data  = {hex_val(line_r[3]), hex_val(line_r[4]), hex_val(line_r[5]),
             hex_val(line_r[6])};

    cmd.kind = CMD_BAD;
    cmd.addr = addr;
    cmd.data = data;
    if (is_s && sr_ok && ({1'b0, addr} < 9'(STATUS_DEPTH))) begin
      cmd.kind = CMD_STATUS;
    end else if (is_r && sr_ok && ({1'b0, addr} < 9'(CONFIG_DEPTH))) begin
      cmd.kind = CMD_READ;
    end else if (is_w && w_ok && ({1'b0, addr} < 9'(CONFIG_DEPTH))) begin
      cmd.kind = CMD_WRITE;
    end
  end

endmodule

// ===== src/ahcrb_reply.sv =====
// reply formatter that sends the reply text one beat at a time
module ahcrb_reply (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  ahcrb_pkg::reply_start_t start_info,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [7:0]              out_tdata,
  output logic                    out_tlast
);
  import ahcrb_pkg::*;

  logic        active_r, active_nxt;
  reply_kind_t kind_r;
  logic [15:0] word_r;
  logic [2:0]  idx_r, idx_nxt;
  logic        beat;

  assign beat = active_r && out_tready;

  always_comb begin
    out_tdata = CH_LF;
    out_tlast = 1'b0;
    case (kind_r)
      RPL_WORD: begin
        case (idx_r)
          3'd0:    out_tdata = hex_char(word_r[15:12]);
          3'd1:    out_tdata = hex_char(word_r[11:8]);
          3'd2:    out_tdata = hex_char(word_r[7:4]);
          3'd3:    out_tdata = hex_char(word_r[3:0]);
          3'd4:    out_tdata = CH_CR;
          default: out_tdata = CH_LF;
        endcase
        out_tlast = (idx_r == 3'd5);
      end
      RPL_OK: begin
        case (idx_r)
          3'd0:    out_tdata = CH_O;
          3'd1:    out_tdata = CH_K;
          3'd2:    out_tdata = CH_CR;
          default: out_tdata = CH_LF;
        endcase
        out_tlast = (idx_r == 3'd3);
      end
      default: begin
        case (idx_r)
          3'd0:    out_tdata = CH_QUERY;
          3'd1:    out_tdata = CH_CR;
          default: out_tdata = CH_LF;
        endcase
        out_tlast = (idx_r == 3'd2);
      end
    endcase
  end

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (start) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
    end else if (beat) begin
      if (out_tlast) begin
        active_nxt = 1'b0;
      end
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kind_r <= start_info.kind;
      word_r <= start_info.word;
    end
  end

  assign out_tvalid = active_r;

endmodule

// ===== src/ascii_hex_command_register_bridge.sv =====
// top level of the ascii hex command bridge between uart bytes and word stores
//
//  channel | dir | handshake        | payload
//  in_     | in  | in_tvalid/tready | tuser: op; tdata: rx_byte, status_addr, status_value
//  out_    | out | out_tvalid/tready| tdata: tx_byte; tlast: last
//
// after reset a clearing pass zeroes both stores, with in_tready low
// a plain byte or a status update is taken one beat per cycle while in ST_IDLE
// a newline is accepted in ST_IDLE and decoded in ST_DECODE, S and R replies read the store in
// ST_FETCH, then ST_SEND sends one reply beat per cycle; out_tready low stalls the reply
// the registered store read is what adds the ST_FETCH state to S and R replies
module ascii_hex_command_register_bridge (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // rx_byte[7:0], status_addr[15:8], status_value[31:16]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // tx_byte[7:0]
  output logic        out_tlast
);
  import ahcrb_pkg::*;

  `include "ascii_hex_command_register_bridge_defines.svh"

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_DECODE = 5'b00100,
    ST_FETCH  = 5'b01000,
    ST_SEND   = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic         accept, byte_push, clearing;
  line_cmd_t    cmd;
  reply_start_t rpl_info;
  logic         rpl_start;

  logic              cfg_we, cfg_re, st_we, st_re;
  logic [CFG_AW-1:0] cfg_waddr;
  logic [ST_AW-1:0]  st_waddr;
  logic [15:0]       cfg_wdata, st_wdata, cfg_rdata, st_rdata;

  assign accept    = in_tvalid && in_tready;
  assign byte_push = accept && !in_tuser;
  assign clearing  = (state_r == ST_CLEAR);
  assign in_tready = (state_r == ST_IDLE);

  ahcrb_line u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (byte_push),
    .push_byte (in_tdata[7:0]),
    .cmd       (cmd)
  );

  always_comb begin
    st_we    = 1'b0;
    st_waddr = in_tdata[ST_AW+7:8];
    st_wdata = in_tdata[31:16];
    cfg_we    = 1'b0;
    cfg_waddr = cmd.addr[CFG_AW-1:0];
    cfg_wdata = cmd.data;
    if (clearing) begin
      st_we     = ({1'b0, clr_cnt_r} < (CLR_W+1)'(STATUS_DEPTH));
      st_waddr  = clr_cnt_r[ST_AW-1:0];
      st_wdata  = '0;
      cfg_we    = ({1'b0, clr_cnt_r} < (CLR_W+1)'(CONFIG_DEPTH));
      cfg_waddr = clr_cnt_r[CFG_AW-1:0];
      cfg_wdata = '0;
    end else begin
      st_we  = accept && in_tuser && ({1'b0, in_tdata[15:8]} < 9'(STATUS_DEPTH));
      cfg_we = (state_r == ST_DECODE) && (cmd.kind == CMD_WRITE);
    end
  end

  assign cfg_re = (state_r == ST_DECODE) && (cmd.kind == CMD_READ);
  assign st_re  = (state_r == ST_DECODE) && (cmd.kind == CMD_STATUS);

  ahcrb_ram #(.WIDTH(16), .DEPTH(CONFIG_DEPTH)) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (cfg_waddr),
    .wdata (cfg_wdata),
    .re    (cfg_re),
    .raddr (cmd.addr[CFG_AW-1:0]),
    .rdata (cfg_rdata)
  );

  ahcrb_ram #(.WIDTH(16), .DEPTH(STATUS_DEPTH)) u_st_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (cmd.addr[ST_AW-1:0]),
    .rdata (st_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    rpl_start     = 1'b0;
    rpl_info.kind = RPL_ERR;
    rpl_info.word = (cmd.kind == CMD_READ) ? cfg_rdata : st_rdata;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_W'(CLR_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (byte_push && (in_tdata[7:0] == CH_LF)) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if ((cmd.kind == CMD_STATUS) || (cmd.kind == CMD_READ)) begin
          state_nxt = ST_FETCH;
        end else begin
          rpl_start     = 1'b1;
          rpl_info.kind = (cmd.kind == CMD_WRITE) ? RPL_OK : RPL_ERR;
          state_nxt     = ST_SEND;
        end
      end
      ST_FETCH: begin
        rpl_start     = 1'b1;
        rpl_info.kind = RPL_WORD;
        state_nxt     = ST_SEND;
      end
      ST_SEND: begin
        if (out_tvalid && out_tready && out_tlast) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  ahcrb_reply u_reply (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (rpl_start),
    .start_info (rpl_info),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `AHCRB_ASSERT(a_no_accept_while_reply, !(in_tready && out_tvalid), "input taken during a reply")
  `AHCRB_ASSERT(a_cfg_write_in_decode, !(cfg_we && !clearing) || (state_r == ST_DECODE), "config write outside decode")
  `AHCRB_ASSERT_NEXT(a_idle_after_reply, out_tvalid && out_tready && out_tlast, in_tready && !out_tvalid, "block not idle after final reply beat")

endmodule

// ===== verif/tb.sv =====
// self-checking testbench of the ascii hex command register bridge
module tb;
  import ahcrb_pkg::*;

  localparam logic OP_RX     = 1'b0;
  localparam logic OP_STATUS = 1'b1;
  localparam int   HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } reply_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  logic [7:0]  line_buf [LINE_BYTES];
  int          line_len;
  logic [15:0] cfg_words [CONFIG_DEPTH];
  logic [15:0] status_words [STATUS_DEPTH];
  reply_beat_t expected_replies [$];
  logic [7:0]  line_bytes [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int fail_count = 0;
  int hold_requests = 0;

  ascii_hex_command_register_bridge DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [7:0] nibble_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return CH_0 + {4'd0, n};
    return (lower ? CH_A_LO : CH_A_UP) + {4'd0, n} - 8'd10;
  endfunction

  function automatic int digit_value(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_A_UP && c <= CH_F_UP) return int'(c - CH_A_UP) + 10;
    if (c >= CH_A_LO && c <= CH_F_LO) return int'(c - CH_A_LO) + 10;
    return -1;
  endfunction

  function automatic bit parse_digits(input int pos, input int n, output logic [15:0] val);
    int d;
    val = '0;
    for (int i = 0; i < n; i++) begin
      d = digit_value(line_buf[pos + i]);
      if (d < 0) return 1'b0;
      val = {val[11:0], d[3:0]};
    end
    return 1'b1;
  endfunction

  function automatic void push_reply(input logic [7:0] ch, input logic last);
    expected_replies.push_back({ch, last});
  endfunction

  function automatic void push_word(input logic [15:0] w);
    for (int i = 3; i >= 0; i--) push_reply(nibble_char(w[i*4 +: 4], 1'b0), 1'b0);
    push_reply(CH_CR, 1'b0);
    push_reply(CH_LF, 1'b1);
  endfunction

  function automatic void decode_line();
    logic [7:0]  cmd;
    logic [15:0] addr;
    logic [15:0] data;
    cmd = line_buf[0];
    if (cmd == CH_S_UP || cmd == CH_S_LO || cmd == CH_R_UP || cmd == CH_R_LO) begin
      if (parse_digits(1, 2, addr) && line_buf[3] == CH_CR && line_buf[4] == CH_LF) begin
        if (cmd == CH_S_UP || cmd == CH_S_LO) begin
          if (addr < STATUS_DEPTH) begin
            push_word(status_words[addr]);
            return;
          end
        end else if (addr < CONFIG_DEPTH) begin
          push_word(cfg_words[addr]);
          return;
        end
      end
    end else if (cmd == CH_W_UP || cmd == CH_W_LO) begin
      if (parse_digits(1, 2, addr) && parse_digits(3, 4, data) && line_buf[7] == CH_CR &&
          line_buf[8] == CH_LF && addr < CONFIG_DEPTH) begin
        cfg_words[addr] = data;
        push_reply(CH_O, 1'b0);
        push_reply(CH_K, 1'b0);
        push_reply(CH_CR, 1'b0);
        push_reply(CH_LF, 1'b1);
        return;
      end
    end
    push_reply(CH_QUERY, 1'b0);
    push_reply(CH_CR, 1'b0);
    push_reply(CH_LF, 1'b1);
  endfunction

  function automatic void note_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : predict_replies
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tuser == OP_STATUS) begin
        if (int'(in_tdata[15:8]) < STATUS_DEPTH) status_words[in_tdata[15:8]] = in_tdata[31:16];
      end else begin
        if (line_len < LINE_BYTES) begin
          line_buf[line_len] = in_tdata[7:0];
          line_len++;
        end
        if (in_tdata[7:0] == CH_LF) begin
          line_len = 0;
          decode_line();
        end
      end
    end
  end

  always @(posedge clk) begin : check_replies
    reply_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_replies.size() == 0) begin
        note_error($sformatf("reply beat %h last %b with nothing expected", out_tdata, out_tlast));
      end else begin
        want = expected_replies.pop_front();
        if (out_tdata !== want.ch)
          note_error($sformatf("tx byte: expected %h, got %h", want.ch, out_tdata));
        if (out_tlast !== want.last)
          note_error($sformatf("last flag: expected %b, got %b", want.last, out_tlast));
      end
    end
  end

  initial begin : reply_sink
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_beat(input logic op, input logic [7:0] ch, input logic [7:0] saddr,
                           input logic [15:0] sval);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {sval, saddr, ch};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_beat(OP_RX, ch, 8'($urandom_range(0, 255)), 16'($urandom));
  endtask

  task automatic send_status(input logic [7:0] addr, input logic [15:0] value);
    send_beat(OP_STATUS, 8'($urandom_range(0, 255)), addr, value);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] pick_addr();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void build_good_command();
    cmd_kind_t   kind;
    logic [7:0]  addr;
    logic [15:0] data;
    bit          lower;
    kind  = cmd_kind_t'($urandom_range(1, 3));
    addr  = pick_addr();
    data  = 16'($urandom);
    lower = 1'($urandom_range(0, 1));
    line_bytes.delete();
    case (kind)
      CMD_STATUS: line_bytes.push_back(lower ? CH_S_LO : CH_S_UP);
      CMD_READ:   line_bytes.push_back(lower ? CH_R_LO : CH_R_UP);
      default:    line_bytes.push_back(lower ? CH_W_LO : CH_W_UP);
    endcase
    line_bytes.push_back(nibble_char(addr[7:4], 1'($urandom_range(0, 1))));
    line_bytes.push_back(nibble_char(addr[3:0], 1'($urandom_range(0, 1))));
    if (kind == CMD_WRITE) begin
      for (int i = 3; i >= 0; i--)
        line_bytes.push_back(nibble_char(data[i*4 +: 4], 1'($urandom_range(0, 1))));
    end
    line_bytes.push_back(CH_CR);
    line_bytes.push_back(CH_LF);
  endfunction

  // status updates may land anywhere inside a line
  task automatic send_line();
    for (int i = 0; i < line_bytes.size(); i++) begin
      if ($urandom_range(0, 99) < 5) send_status(pick_addr(), 16'($urandom));
      send_char(line_bytes[i]);
    end
  endtask

  task automatic wait_for_replies();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_commands();
    send_status(8'hFF, 16'hFFFF);
    send_text("sFf");
    send_char(CH_CR);
    send_char(CH_LF);
    send_text("W00aBcD");
    send_char(CH_CR);
    send_char(CH_LF);
  endtask

  task automatic test_line_edge_cases();
    send_text("r0");
    send_status(8'h00, 16'h0000);
    send_text("0");
    send_char(CH_CR);
    send_char(CH_LF);
    send_text("R00R00R00R0");
    send_char(CH_LF);
  endtask

  task automatic test_reply_backpressure();
    int saved;
    saved = send_idle_pct;
    send_idle_pct = 0;
    hold_requests++;
    repeat (6) begin
      build_good_command();
      send_line();
    end
    wait_for_replies();
    send_idle_pct = saved;
  endtask

  task automatic test_random_traffic(input int count);
    int start;
    int pick;
    int pos;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        build_good_command();
        send_line();
      end else if (pick < 78) begin
        send_status(pick_addr(), 16'($urandom));
      end else if (pick < 90) begin
        build_good_command();
        pos = $urandom_range(0, line_bytes.size() - 1);
        if ($urandom_range(0, 1)) line_bytes[pos] = 8'($urandom_range(0, 255));
        else line_bytes.delete(pos);
        if (line_bytes[line_bytes.size() - 1] != CH_LF) line_bytes.push_back(CH_LF);
        send_line();
      end else begin
        line_bytes.delete();
        repeat ($urandom_range(0, 14)) line_bytes.push_back(8'($urandom_range(0, 255)));
        line_bytes.push_back(CH_LF);
        send_line();
      end
    end
  endtask

  initial begin : run_tests
    for (int i = 0; i < LINE_BYTES; i++) line_buf[i] = 8'h00;
    for (int i = 0; i < CONFIG_DEPTH; i++) cfg_words[i] = 16'h0000;
    for (int i = 0; i < STATUS_DEPTH; i++) status_words[i] = 16'h0000;
    line_len = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= 1'b0;
    in_tdata  <= '0;
    send_idle_pct = 11;
    recv_idle_pct = 85;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_commands();
    test_line_edge_cases();
    wait_for_replies();
    test_reply_backpressure();
    test_random_traffic(100);
    wait_for_replies();

    send_idle_pct = 85;
    recv_idle_pct = 11;
    test_random_traffic(100);
    wait_for_replies();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(100);
    wait_for_replies();

    repeat (30) @(posedge clk);
    if (expected_replies.size() != 0)
      note_error($sformatf("%0d reply beats never arrived", expected_replies.size()));
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
